// ----- rtl/c2d_pkg.sv -----
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and constants for the CMPR to DXT1 block converter.
// ----------------------------------------------------------------------------
package c2d_pkg;

  // Fixed field widths.
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned SIZE_REG_W  = 9;
  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned INDEX_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_BLOCKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIP_LEVELS    = 2'd2;

  // Configuration reset values.
  localparam logic [SIZE_REG_W-1:0] WIDTH_RESET  = 9'd2;
  localparam logic [SIZE_REG_W-1:0] HEIGHT_RESET = 9'd2;
  localparam logic [LEVEL_W-1:0]    LEVELS_RESET = 4'd1;

  // Sub-block position inside a 2x2 tile: dy in bit 1, dx in bit 0.
  localparam logic [1:0] SUB_LAST = 2'd3;

  // Index-byte masks for reversing the four 2-bit pixel codes.
  localparam logic [7:0] PAIR0_MASK = 8'h03;
  localparam logic [7:0] PAIR1_MASK = 8'h0C;
  localparam logic [7:0] PAIR2_MASK = 8'h30;
  localparam logic [7:0] PAIR3_MASK = 8'hC0;

  // Per-block position flags handed from the sequencer to the pipeline.
  typedef struct packed {
    logic in_img;
    logic last_lvl;
    logic last_img;
  } c2d_flags_t;

endpackage

// ----- rtl/c2d_swizzle.sv -----
// ----------------------------------------------------------------------------
// c2d_swizzle
// Converts one tiled CMPR block to DXT1 byte order: swaps the bytes of both
// 16-bit colors and reverses the 2-bit pixel codes in each index byte.
// ----------------------------------------------------------------------------
module c2d_swizzle
  import c2d_pkg::*;
(
  input  logic [BLOCK_W-1:0] cmpr_block,
  output logic [BLOCK_W-1:0] dxt_block
);

  // Put the four 2-bit codes of one byte in reverse order.
  function automatic logic [7:0] reverse_pairs(input logic [7:0] b);
    return ((b & PAIR0_MASK) << 6) | ((b & PAIR1_MASK) << 2) |
           ((b & PAIR2_MASK) >> 2) | ((b & PAIR3_MASK) >> 6);
  endfunction

  // Byte swap of the two colors, then the four index bytes.
  always_comb begin
    dxt_block[63:56] = cmpr_block[55:48];
    dxt_block[55:48] = cmpr_block[63:56];
    dxt_block[47:40] = cmpr_block[39:32];
    dxt_block[39:32] = cmpr_block[47:40];
    for (int i = 0; i < 4; i++) begin
      dxt_block[i*8 +: 8] = reverse_pairs(cmpr_block[i*8 +: 8]);
    end
  end

endmodule

// ----- rtl/c2d_seq.sv -----
// ----------------------------------------------------------------------------
// c2d_seq
// Tile-order position sequencer. Holds the configuration registers and walks
// sub-block, tile column, tile row and mip level, one step per transaction.
// ----------------------------------------------------------------------------
module c2d_seq
  import c2d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH_BLOCKS = 256,
  parameter int unsigned MAX_LEVELS       = 9,
  parameter int unsigned LW               = 9,
  parameter int unsigned TW               = 7
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_REG_W-1:0] cfg_data,
  input  logic                  step,
  output logic [LEVEL_W-1:0]    level,
  output logic [LW-1:0]         row,
  output logic [LW-1:0]         col,
  output logic [LW-1:0]         lvl_width,
  output c2d_flags_t            flags
);

  // Clamp a size register to the range of one block to the maximum.
  function automatic logic [LW-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v);
    int unsigned t;
    t = 32'(v);
    if (t < 1) t = 1;
    if (t > MAX_WIDTH_BLOCKS) t = MAX_WIDTH_BLOCKS;
    return LW'(t);
  endfunction

  logic [SIZE_REG_W-1:0] width_r, width_nxt;
  logic [SIZE_REG_W-1:0] height_r, height_nxt;
  logic [LEVEL_W-1:0]    levels_r, levels_nxt;
  logic [LEVEL_W-1:0]    level_r, level_nxt;
  logic [TW-1:0]         tcol_r, tcol_nxt;
  logic [TW-1:0]         trow_r, trow_nxt;
  logic [1:0]            sub_r, sub_nxt;
  logic [LW-1:0]         lw_r, lw_nxt;
  logic [LW-1:0]         lh_r, lh_nxt;

  logic [LW:0]           tiles_x, tiles_y;
  logic [LW:0]           tcol_inc, trow_inc;
  logic [LEVEL_W-1:0]    eff_levels;
  logic [LEVEL_W:0]      level_inc;
  logic                  last_lvl, last_img;

  // Current position of the block about to be taken.
  always_comb begin
    tiles_x   = ({1'b0, lw_r} + 1'b1) >> 1;
    tiles_y   = ({1'b0, lh_r} + 1'b1) >> 1;
    tcol_inc  = (LW+1)'(tcol_r) + 1'b1;
    trow_inc  = (LW+1)'(trow_r) + 1'b1;
    level_inc = {1'b0, level_r} + 1'b1;
    if (levels_r == '0) begin
      eff_levels = LEVEL_W'(1);
    end else if (32'(levels_r) > MAX_LEVELS) begin
      eff_levels = LEVEL_W'(MAX_LEVELS);
    end else begin
      eff_levels = levels_r;
    end
    col       = LW'({tcol_r, sub_r[0]});
    row       = LW'({trow_r, sub_r[1]});
    last_lvl  = (sub_r == SUB_LAST) && (tcol_inc >= tiles_x) && (trow_inc >= tiles_y);
    last_img  = last_lvl && (level_inc >= {1'b0, eff_levels});
    level     = level_r;
    lvl_width = lw_r;
    flags.in_img   = (col < lw_r) && (row < lh_r);
    flags.last_lvl = last_lvl;
    flags.last_img = last_img;
  end

  // Next state: a write to index 0, 1 or 2 restarts the stream, otherwise step on.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    levels_nxt = levels_r;
    level_nxt  = level_r;
    tcol_nxt   = tcol_r;
    trow_nxt   = trow_r;
    sub_nxt    = sub_r;
    lw_nxt     = lw_r;
    lh_nxt     = lh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_BLOCKS:  width_nxt  = cfg_data;
        CFG_HEIGHT_BLOCKS: height_nxt = cfg_data;
        CFG_MIP_LEVELS:    levels_nxt = cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
      if (cfg_index == CFG_WIDTH_BLOCKS || cfg_index == CFG_HEIGHT_BLOCKS ||
          cfg_index == CFG_MIP_LEVELS) begin
        level_nxt = '0;
        tcol_nxt  = '0;
        trow_nxt  = '0;
        sub_nxt   = '0;
        lw_nxt    = clamp_size(width_nxt);
        lh_nxt    = clamp_size(height_nxt);
      end
    end else if (step) begin
      if (last_img) begin
        level_nxt = '0;
        tcol_nxt  = '0;
        trow_nxt  = '0;
        sub_nxt   = '0;
        lw_nxt    = clamp_size(width_r);
        lh_nxt    = clamp_size(height_r);
      end else if (last_lvl) begin
        level_nxt = level_inc[LEVEL_W-1:0];
        tcol_nxt  = '0;
        trow_nxt  = '0;
        sub_nxt   = '0;
        if (lw_r > LW'(1)) lw_nxt = lw_r >> 1;
        if (lh_r > LW'(1)) lh_nxt = lh_r >> 1;
      end else if (sub_r != SUB_LAST) begin
        sub_nxt = sub_r + 2'd1;
      end else begin
        sub_nxt = '0;
        if (tcol_inc < tiles_x) begin
          tcol_nxt = tcol_inc[TW-1:0];
        end else begin
          tcol_nxt = '0;
          trow_nxt = trow_inc[TW-1:0];
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      levels_r <= LEVELS_RESET;
      level_r  <= '0;
      tcol_r   <= '0;
      trow_r   <= '0;
      sub_r    <= '0;
      lw_r     <= clamp_size(WIDTH_RESET);
      lh_r     <= clamp_size(HEIGHT_RESET);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      levels_r <= levels_nxt;
      level_r  <= level_nxt;
      tcol_r   <= tcol_nxt;
      trow_r   <= trow_nxt;
      sub_r    <= sub_nxt;
      lw_r     <= lw_nxt;
      lh_r     <= lh_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A level never shrinks below one block.
  a_width_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (lw_r != '0) && (lh_r != '0))
    else $error("level size dropped to zero");

  // The level counter stays below the effective level count.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r < eff_levels)
    else $error("level counter beyond last level");

  // The last block of the image always restarts the sequence.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && !cfg_we && last_img |=> (level_r == '0) && (sub_r == '0))
    else $error("no restart after last block of image");
`endif

endmodule

// ----- rtl/cmpr_to_dxt1_block_converter_top.sv -----
// ----------------------------------------------------------------------------
// cmpr_to_dxt1_block_converter_top
// Converts tile-ordered CMPR blocks of a mip chain to DXT1 and tags each with
// its level, raster block index and tile padding flags.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, the input stage and the result register; an
//   accepted block waits in the input stage until the result register can take it.
// Throughput: one block per cycle while out_stall is low; the limit is the position
//   stage plus one index multiply and add in the output stage.
// Reset (synchronous, rst_n low): registers take width 2, height 2, one level,
//   the sequence restarts at level zero and both pipeline stages empty.
module cmpr_to_dxt1_block_converter_top
  import c2d_pkg::*;
#(
  parameter int unsigned MAX_WIDTH_BLOCKS = 256,
  parameter int unsigned MAX_LEVELS       = 9
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_REG_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BLOCK_W-1:0]    in_cmpr_block,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BLOCK_W-1:0]    out_dxt_block,
  output logic [LEVEL_W-1:0]    out_mip_level,
  output logic [INDEX_W-1:0]    out_block_index,
  output logic                  out_in_image,
  output logic                  out_last_of_level,
  output logic                  out_last_of_image
);

  localparam int unsigned LW    = $clog2(MAX_WIDTH_BLOCKS + 1);
  localparam int unsigned TILES = (MAX_WIDTH_BLOCKS + 1) / 2;
  localparam int unsigned TW    = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int unsigned PW    = 2 * LW + 1;
  localparam int unsigned IW    = (PW > INDEX_W) ? PW : INDEX_W;

  logic               in_acc, s2_adv;
  logic [LEVEL_W-1:0] seq_level;
  logic [LW-1:0]      seq_row, seq_col, seq_width;
  c2d_flags_t         seq_flags;

  logic               s1_valid_r, s1_valid_nxt;
  logic [BLOCK_W-1:0] s1_data_r;
  logic [LEVEL_W-1:0] s1_level_r;
  logic [LW-1:0]      s1_row_r, s1_col_r, s1_width_r;
  c2d_flags_t         s1_flags_r;

  logic               out_valid_r, out_valid_nxt;
  logic [BLOCK_W-1:0] out_data_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [INDEX_W-1:0] out_index_r;
  c2d_flags_t         out_flags_r;

  logic [BLOCK_W-1:0] swz_block;
  logic [IW-1:0]      raster_idx;

  // Handshake: stage one refills whenever it is empty or moves on.
  assign cfg_ready = 1'b1;
  assign s2_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s2_adv;
  assign in_acc    = in_valid && !in_stall;

  c2d_seq #(
    .MAX_WIDTH_BLOCKS (MAX_WIDTH_BLOCKS),
    .MAX_LEVELS       (MAX_LEVELS),
    .LW               (LW),
    .TW               (TW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_acc),
    .level     (seq_level),
    .row       (seq_row),
    .col       (seq_col),
    .lvl_width (seq_width),
    .flags     (seq_flags)
  );

  // Input stage valid control.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s2_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input stage payload: block data and its position.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r  <= in_cmpr_block;
      s1_level_r <= seq_level;
      s1_row_r   <= seq_row;
      s1_col_r   <= seq_col;
      s1_width_r <= seq_width;
      s1_flags_r <= seq_flags;
    end
  end

  c2d_swizzle u_swizzle (
    .cmpr_block (s1_data_r),
    .dxt_block  (swz_block)
  );

  // Raster index within the level, cut to 16 bits in the result register.
  assign raster_idx = IW'(s1_row_r) * IW'(s1_width_r) + IW'(s1_col_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_adv) begin
      out_data_r  <= swz_block;
      out_level_r <= s1_level_r;
      out_index_r <= s1_flags_r.in_img ? raster_idx[INDEX_W-1:0] : '0;
      out_flags_r <= s1_flags_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_dxt_block     = out_data_r;
  assign out_mip_level     = out_level_r;
  assign out_block_index   = out_index_r;
  assign out_in_image      = out_flags_r.in_img;
  assign out_last_of_level = out_flags_r.last_lvl;
  assign out_last_of_image = out_flags_r.last_img;

`ifndef ASSERT_OFF
  // Input is held back only while stage one holds a transaction.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty stage");

  // A waiting result is not dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost");

  // End of image is always end of a level.
  a_last_nest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.last_img |-> out_flags_r.last_lvl)
    else $error("last of image without last of level");

  // Padding blocks carry index zero.
  a_pad_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_flags_r.in_img |-> out_index_r == '0)
    else $error("padding block with nonzero index");
`endif

endmodule
